@@ rtl/mtce_pkg.sv @@
// Shared types and constants for the markup tag content extractor.
// Used by mtce_ctrl, mtce_dp and the top level.
package mtce_pkg;

  // Characters the scanner looks for
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;  // process the byte on the input port
    logic step;     // pop and process the top of the replay stack
    logic push;     // push one held byte onto the replay stack
    logic flush;    // one end-of-data step
    logic drain;    // hand the pending result to the output, marked last
  } ctl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mismatch;     // current byte breaks a partial closing match
    logic emit;         // current step produces a result
    logic stack_empty;  // nothing left to replay
    logic emit_ok;      // a new result can be taken this cycle
    logic push_last;    // this push is the last of the replay sequence
    logic flush_last;   // this flush step finishes end-of-data handling
    logic pend_valid;   // a result waits in the pending register
    logic out_free;     // output register can load this cycle
  } ctl_sts_t;

  // Text after '<' of a head tag: "head"
  function automatic logic [7:0] head_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h68;  // h
      2'd1:    c = 8'h65;  // e
      2'd2:    c = 8'h61;  // a
      default: c = 8'h64;  // d
    endcase
    return c;
  endfunction

  // Text after '<' of a doctype tag: "!DOCTYPE"
  function automatic logic [7:0] doctype_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h21;  // !
      3'd1:    c = 8'h44;  // D
      3'd2:    c = 8'h4F;  // O
      3'd3:    c = 8'h43;  // C
      3'd4:    c = 8'h54;  // T
      3'd5:    c = 8'h59;  // Y
      3'd6:    c = 8'h50;  // P
      default: c = 8'h45;  // E
    endcase
    return c;
  endfunction

endpackage

@@ rtl/mtce_ctrl.sv @@
// Sequencing controller for the markup tag content extractor.
// Depends on mtce_pkg; drives mtce_dp through ctl_cmd_t / ctl_sts_t.
module mtce_ctrl
  import mtce_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     is_last,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_PUSH,
    S_FLUSH,
    S_DRAIN
  } state_t;

  state_t state, state_next;
  logic   last_q;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take_in = 1'b1;
          if (sts.mismatch)  state_next = S_PUSH;
          else if (is_last)  state_next = S_FLUSH;
          else if (sts.emit) state_next = S_DRAIN;
        end
      end
      S_PROC: begin
        if (sts.stack_empty) begin
          state_next = last_q ? S_FLUSH : S_DRAIN;
        end else if (sts.emit_ok) begin
          cmd.step = 1'b1;
          if (sts.mismatch) state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (sts.push_last) state_next = S_PROC;
      end
      S_FLUSH: begin
        if (sts.emit_ok) begin
          cmd.flush = 1'b1;
          if (sts.flush_last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.drain  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, end-of-document flag and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
      last_q   <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
      if (cmd.take_in) last_q <= is_last;
    end
  end

endmodule

@@ rtl/mtce_dp.sv @@
// Datapath of the markup tag content extractor: scanner state, tag name
// store, replay stack and result registers. Depends on mtce_pkg.
module mtce_dp
  import mtce_pkg::*;
#(
  parameter int MAX_NAME = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_cmd_t   cmd,
  output ctl_sts_t   sts,
  input  logic [7:0] byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] value,
  output logic       last_of_run
);

  localparam int QCAP = MAX_NAME + 4;
  localparam int NIW  = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int LW   = $clog2(MAX_NAME + 1);
  localparam int HW   = $clog2(MAX_NAME + 3);
  localparam int SPW  = $clog2(QCAP + 1);
  localparam int SIW  = $clog2(QCAP);

  localparam logic [HW:0]    NAME_LIM = (HW + 1)'(MAX_NAME);
  localparam logic [LW-1:0]  LEN_LIM  = LW'(MAX_NAME);
  localparam logic [SPW-1:0] SP_LIM   = SPW'(QCAP);

  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_TAG,
    MODE_SKIP,
    MODE_CAPTURE
  } mode_t;

  // Scanner state
  mode_t         mode, mode_next;
  logic [3:0]    tag_pos, tag_pos_next;
  logic [7:0]    name_store [MAX_NAME];
  logic [LW-1:0] name_len, name_len_next;
  logic          name_closed, name_closed_next;
  logic          head_match, head_match_next;
  logic          doctype_match, doctype_match_next;
  logic [HW-1:0] hold_len, hold_len_next;

  // Replay stack and its sequencing
  logic [7:0]     stack [QCAP];
  logic [SPW-1:0] sp, sp_next, sp_m1;
  logic           push_b, push_b_next;
  logic [7:0]     push_byte, push_byte_next;
  logic [HW-1:0]  seq_k, seq_k_next;

  // Pending and output result registers
  logic       pend_valid;
  logic       pend_kind;
  logic [7:0] pend_value;

  logic          do_step, name_we, st_we, load_out;
  logic [7:0]    src, stack_top, cc, st_wdata;
  logic [HW-1:0] rd_k, rd_idx;
  logic [HW:0]   hold_inc, full_len;
  logic          e_valid, e_kind, mismatch, out_free;
  logic [7:0]    e_value;

  // Closing-text read port: byte k of "</" + name
  assign rd_k   = (cmd.push || cmd.flush) ? seq_k : hold_len;
  assign rd_idx = rd_k - HW'(2);
  always_comb begin
    if (rd_k == HW'(0))                 cc = CH_LT;
    else if (rd_k == HW'(1))            cc = CH_SLASH;
    else if ({1'b0, rd_idx} < NAME_LIM) cc = name_store[rd_idx[NIW-1:0]];
    else                                cc = 8'h00;
  end

  assign sp_m1     = sp - SPW'(1);
  assign stack_top = stack[sp_m1[SIW-1:0]];
  assign src       = cmd.take_in ? byte_in : stack_top;
  assign do_step   = cmd.take_in | cmd.step;
  assign hold_inc  = {1'b0, hold_len} + (HW + 1)'(1);
  assign full_len  = (HW + 1)'(name_len) + (HW + 1)'(2);
  assign out_free  = !out_valid || out_ready;

  // One scan step per cycle while the controller issues take_in or step
  always_comb begin
    mode_next          = mode;
    tag_pos_next       = tag_pos;
    name_len_next      = name_len;
    name_closed_next   = name_closed;
    head_match_next    = head_match;
    doctype_match_next = doctype_match;
    hold_len_next      = hold_len;
    sp_next            = sp;
    push_b_next        = push_b;
    push_byte_next     = push_byte;
    seq_k_next         = seq_k;
    name_we            = 1'b0;
    st_we              = 1'b0;
    st_wdata           = cc;
    e_valid            = 1'b0;
    e_kind             = KIND_DATA;
    e_value            = 8'h00;
    mismatch           = 1'b0;

    if (do_step) begin
      case (mode)
        MODE_SEARCH: begin
          if (src == CH_LT) begin
            mode_next          = MODE_TAG;
            tag_pos_next       = 4'd0;
            name_len_next      = '0;
            name_closed_next   = 1'b0;
            head_match_next    = 1'b1;
            doctype_match_next = 1'b1;
          end
        end
        MODE_TAG: begin
          if (src == CH_GT) begin
            hold_len_next = '0;
            if (head_match && tag_pos >= 4'd4)         mode_next = MODE_SKIP;
            else if (doctype_match && tag_pos >= 4'd8) mode_next = MODE_SEARCH;
            else                                       mode_next = MODE_CAPTURE;
          end else begin
            if (tag_pos < 4'd4 && src != head_char(tag_pos[1:0]))
              head_match_next = 1'b0;
            if (tag_pos < 4'd8 && src != doctype_char(tag_pos[2:0]))
              doctype_match_next = 1'b0;
            if (tag_pos != 4'd15) tag_pos_next = tag_pos + 4'd1;
            if (!name_closed) begin
              if (src == CH_SPACE) begin
                name_closed_next = 1'b1;
              end else if (name_len < LEN_LIM) begin
                name_we       = 1'b1;
                name_len_next = name_len + LW'(1);
              end
            end
          end
        end
        default: begin
          // skip or capture: watch for "</" + name
          if (hold_len == '0) begin
            if (src == CH_LT) begin
              hold_len_next = HW'(1);
            end else if (mode == MODE_CAPTURE) begin
              e_valid = 1'b1;
              e_value = src;
            end
          end else if (src == cc) begin
            if (hold_inc >= full_len) begin
              hold_len_next = '0;
              mode_next     = MODE_SEARCH;
              if (mode == MODE_CAPTURE) begin
                e_valid = 1'b1;
                e_kind  = KIND_END;
              end
            end else begin
              hold_len_next = hold_inc[HW-1:0];
            end
          end else begin
            // broken match: release '<' in capture, replay the rest and this byte
            mismatch       = 1'b1;
            hold_len_next  = '0;
            push_b_next    = 1'b1;
            push_byte_next = src;
            seq_k_next     = hold_len - HW'(1);
            if (mode == MODE_CAPTURE) begin
              e_valid = 1'b1;
              e_value = CH_LT;
            end
          end
        end
      endcase
      if (cmd.step) sp_next = sp_m1;
    end else if (cmd.push) begin
      // held bytes go on the stack so the oldest is popped first
      st_wdata = push_b ? push_byte : cc;
      if (sp < SP_LIM) begin
        st_we   = 1'b1;
        sp_next = sp + SPW'(1);
      end
      if (push_b) push_b_next = 1'b0;
      else        seq_k_next  = seq_k - HW'(1);
    end else if (cmd.flush) begin
      // end of document: open capture releases held bytes, then end marker
      if (mode == MODE_CAPTURE && seq_k != hold_len) begin
        e_valid    = 1'b1;
        e_value    = cc;
        seq_k_next = seq_k + HW'(1);
      end else begin
        if (mode == MODE_CAPTURE) begin
          e_valid = 1'b1;
          e_kind  = KIND_END;
        end
        mode_next          = MODE_SEARCH;
        tag_pos_next       = 4'd0;
        name_len_next      = '0;
        name_closed_next   = 1'b0;
        head_match_next    = 1'b0;
        doctype_match_next = 1'b0;
        hold_len_next      = '0;
        seq_k_next         = '0;
      end
    end
  end

  assign load_out = (e_valid && pend_valid) || (cmd.drain && pend_valid);

  // Status to the controller
  always_comb begin
    sts             = '0;
    sts.mismatch    = mismatch;
    sts.emit        = e_valid;
    sts.stack_empty = (sp == '0);
    sts.emit_ok     = !pend_valid || out_free;
    sts.push_last   = push_b ? (seq_k == '0) : (seq_k == HW'(1));
    sts.flush_last  = (mode != MODE_CAPTURE) || (seq_k == hold_len);
    sts.pend_valid  = pend_valid;
    sts.out_free    = out_free;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_SEARCH;
      tag_pos       <= 4'd0;
      name_len      <= '0;
      name_closed   <= 1'b0;
      head_match    <= 1'b0;
      doctype_match <= 1'b0;
      hold_len      <= '0;
      sp            <= '0;
      push_b        <= 1'b0;
      seq_k         <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      tag_pos       <= tag_pos_next;
      name_len      <= name_len_next;
      name_closed   <= name_closed_next;
      head_match    <= head_match_next;
      doctype_match <= doctype_match_next;
      hold_len      <= hold_len_next;
      sp            <= sp_next;
      push_b        <= push_b_next;
      seq_k         <= seq_k_next;
      if (e_valid)     pend_valid <= 1'b1;
      else if (cmd.drain) pend_valid <= 1'b0;
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload: name store, replay stack, pending and output results
  always_ff @(posedge clk) begin
    push_byte <= push_byte_next;
    if (name_we) name_store[name_len[NIW-1:0]] <= src;
    if (st_we)   stack[sp[SIW-1:0]] <= st_wdata;
    if (load_out) begin
      kind        <= pend_kind;
      value       <= pend_value;
      last_of_run <= !e_valid;
    end
    if (e_valid) begin
      pend_kind  <= e_kind;
      pend_value <= e_value;
    end
  end

endmodule

@@ rtl/markup_tag_content_extractor_top.sv @@
// Top level of the markup tag content extractor.
// Instantiates mtce_ctrl and mtce_dp; depends on mtce_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_ready  byte_in[7:0], is_last
//   out      output     out_valid/out_ready  kind, value[7:0], last_of_run
//
// A byte is scanned, then handed off in a further step if it has a result.
// A broken closing-tag match with h held bytes is scanned, then takes h pushes
// onto the replay stack, h rescans, an empty-stack check and a drain step.
// The last byte of a document is scanned, flushed and drained, with one flush
// step per held byte plus one end marker in a capture, a single one otherwise.
// Reset is synchronous; a stalled output holds the block once both the output
// and pending registers are full.
module markup_tag_content_extractor_top
  import mtce_pkg::*;
#(
  parameter int MAX_NAME = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] value,
  output logic       last_of_run
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mtce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .is_last  (is_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtce_dp #(
    .MAX_NAME (MAX_NAME)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .value       (value),
    .last_of_run (last_of_run)
  );

endmodule

@@ dv/markup_tag_content_extractor_top_test.sv @@
// Self-checking testbench for markup_tag_content_extractor_top.
// Holds its own scanner model with a queue of expected results; needs mtce_pkg and the RTL.
`timescale 1ns / 100ps

module markup_tag_content_extractor_top_test
  import mtce_pkg::*;
;

  localparam int NAME_MAX    = 16;
  localparam int REPLAY_MAX  = NAME_MAX + 4;
  localparam int RUN_MAX     = 32;
  localparam logic [31:0] HEAD_TXT    = "head";
  localparam logic [63:0] DOCTYPE_TXT = "!DOCTYPE";

  typedef enum logic [2:0] {
    SCAN_SEARCH  = 3'd0,
    SCAN_TAG     = 3'd1,
    SCAN_SKIP    = 3'd2,
    SCAN_CAPTURE = 3'd3
  } scan_mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } extract_t;

  // DUT connections
  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] byte_in     = 8'h00;
  logic       is_last     = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic       kind;
  logic [7:0] value;
  logic       last_of_run;

  // Scanner model state
  scan_mode_t mode_q;
  logic [3:0] tag_pos_q;
  logic [7:0] name_q [NAME_MAX];
  logic [4:0] name_len_q;
  logic       name_closed_q;
  logic       head_ok_q;
  logic       doctype_ok_q;
  logic [4:0] hold_q;

  // Replay stack and results of the byte being scanned
  logic [7:0] replay [REPLAY_MAX];
  int         replay_sp;
  extract_t   run_buf [RUN_MAX];
  int         run_cnt;

  extract_t   extract_q [$];
  logic [7:0] doc_q [$];
  logic [7:0] tag_name [$];
  extract_t   got;
  extract_t   want;
  int         mismatch_count = 0;
  int         snd_idle_pct   = 0;
  int         rcv_stall_pct  = 0;
  int         bytes_sent     = 0;

  markup_tag_content_extractor_top #(
    .MAX_NAME(NAME_MAX)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .value      (value),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scanner model
  // ---------------------------------------------------------------------------

  function automatic void scanner_reset();
    mode_q        = SCAN_SEARCH;
    tag_pos_q     = '0;
    name_len_q    = '0;
    name_closed_q = 1'b0;
    head_ok_q     = 1'b0;
    doctype_ok_q  = 1'b0;
    hold_q        = '0;
    for (int i = 0; i < NAME_MAX; i++) name_q[4'(i)] = 8'h00;
  endfunction

  // Byte k of the closing text "</" + name
  function automatic logic [7:0] closing_char(input int k);
    if (k == 0) return CH_LT;
    if (k == 1) return CH_SLASH;
    if (k - 2 < NAME_MAX) return name_q[4'(k - 2)];
    return 8'h00;
  endfunction

  function automatic void add_result(input logic k, input logic [7:0] v);
    extract_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    run_buf[5'(run_cnt)] = r;
    run_cnt++;
  endfunction

  function automatic void replay_push(input logic [7:0] b);
    if (replay_sp < REPLAY_MAX) begin
      replay[5'(replay_sp)] = b;
      replay_sp++;
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    int  pos;
    int  full;
    int  h;
    logic cap;
    pos = int'(tag_pos_q);
    case (mode_q)
      SCAN_SEARCH: begin
        if (b == CH_LT) begin
          mode_q        = SCAN_TAG;
          tag_pos_q     = '0;
          name_len_q    = '0;
          name_closed_q = 1'b0;
          head_ok_q     = 1'b1;
          doctype_ok_q  = 1'b1;
        end
      end
      SCAN_TAG: begin
        if (b == CH_GT) begin
          hold_q = '0;
          if (head_ok_q && pos >= 4) mode_q = SCAN_SKIP;
          else if (doctype_ok_q && pos >= 8) mode_q = SCAN_SEARCH;
          else mode_q = SCAN_CAPTURE;
        end else begin
          if (pos < 4 && b != HEAD_TXT[8*(3-pos) +: 8]) head_ok_q = 1'b0;
          if (pos < 8 && b != DOCTYPE_TXT[8*(7-pos) +: 8]) doctype_ok_q = 1'b0;
          if (pos < 15) tag_pos_q = tag_pos_q + 4'd1;
          if (!name_closed_q) begin
            if (b == CH_SPACE) begin
              name_closed_q = 1'b1;
            end else if (int'(name_len_q) < NAME_MAX) begin
              name_q[name_len_q[3:0]] = b;
              name_len_q = name_len_q + 5'd1;
            end
          end
        end
      end
      default: begin
        cap  = (mode_q == SCAN_CAPTURE);
        full = int'(name_len_q) + 2;
        if (hold_q == 0) begin
          if (b == CH_LT) hold_q = 5'd1;
          else if (cap) add_result(KIND_DATA, b);
        end else if (b == closing_char(int'(hold_q))) begin
          hold_q = hold_q + 5'd1;
          if (int'(hold_q) >= full) begin
            hold_q = '0;
            mode_q = SCAN_SEARCH;
            if (cap) add_result(KIND_END, 8'h00);
          end
        end else begin
          // broken match: release '<' in capture, rescan the rest in order
          h = int'(hold_q);
          hold_q = '0;
          if (cap) add_result(KIND_DATA, CH_LT);
          replay_push(b);
          for (int k = h - 1; k >= 1; k--) replay_push(closing_char(k));
        end
      end
    endcase
  endfunction

  // Run one accepted byte through the model and queue its results
  function automatic void predict_extract(input logic [7:0] b, input logic fin);
    logic [7:0] top;
    extract_t   r;
    run_cnt   = 0;
    replay_sp = 0;
    replay_push(b);
    while (replay_sp > 0) begin
      replay_sp--;
      top = replay[5'(replay_sp)];
      scan_byte(top);
    end
    if (fin) begin
      if (mode_q == SCAN_CAPTURE) begin
        for (int k = 0; k < int'(hold_q); k++) add_result(KIND_DATA, closing_char(k));
        add_result(KIND_END, 8'h00);
      end
      scanner_reset();
    end
    for (int i = 0; i < run_cnt; i++) begin
      r      = run_buf[5'(i)];
      r.last = (i == run_cnt - 1);
      extract_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  // Random output stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got.kind  = kind;
      got.value = value;
      got.last  = last_of_run;
      if (extract_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%02h last_of_run=%0d",
                 $time, got.kind, got.value, got.last);
        mismatch_count++;
      end else begin
        want = extract_q.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
          mismatch_count++;
        end
        if (got.value !== want.value) begin
          $display("%0t: value expected %02h actual %02h", $time, want.value, got.value);
          mismatch_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // One input transfer; valid stays high until the next call or a pause
  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    is_last  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_extract(b, fin);
    bytes_sent++;
  endtask

  task automatic send_doc(input logic fin);
    for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], fin && (i == doc_q.size() - 1));
    doc_q.delete();
  endtask

  // Drop valid and hold off until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (extract_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endtask

  task automatic add_name();
    for (int i = 0; i < tag_name.size(); i++) doc_q.push_back(tag_name[i]);
  endtask

  // Mostly short names over a small alphabet, sometimes empty or overlong
  task automatic make_name();
    int sel;
    int len;
    sel = $urandom_range(0, 9);
    if (sel == 0) len = 0;
    else if (sel == 1) len = $urandom_range(NAME_MAX, NAME_MAX + 3);
    else len = $urandom_range(1, 4);
    tag_name.delete();
    for (int i = 0; i < len; i++) tag_name.push_back(8'($urandom_range(8'h61, 8'h64)));
  endtask

  // Element body: random bytes, letters and broken closing tags
  task automatic add_content();
    int cnt;
    int plen;
    cnt = $urandom_range(0, 6);
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 3))
        0, 1: doc_q.push_back(8'($urandom_range(0, 255)));
        2: begin
          add_text("</");
          plen = (tag_name.size() > 1) ? $urandom_range(0, tag_name.size() - 1) : 0;
          for (int j = 0; j < plen; j++) doc_q.push_back(tag_name[j]);
          doc_q.push_back(8'($urandom_range(0, 255)));
        end
        default: doc_q.push_back(8'($urandom_range(8'h61, 8'h64)));
      endcase
    end
  endtask

  task automatic add_element();
    add_text("<");
    add_name();
    if ($urandom_range(0, 3) == 0) add_text(" x=1");
    add_text(">");
    add_content();
    add_text("</");
    add_name();
    add_text(">");
  endtask

  // One random document, optionally cut short, last byte flagged
  task automatic rand_doc();
    int cut;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) doc_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      add_text("<!DOCTYPE");
      if ($urandom_range(0, 1)) add_text(" html");
      add_text(">");
    end
    if ($urandom_range(0, 3) == 0) begin
      tag_name.delete();
      tag_name.push_back("h");
      tag_name.push_back("e");
      tag_name.push_back("a");
      tag_name.push_back("d");
      if ($urandom_range(0, 2) == 0) tag_name.push_back(8'($urandom_range(8'h61, 8'h64)));
      add_element();
    end
    for (int i = $urandom_range(1, 2); i > 0; i--) begin
      make_name();
      add_element();
    end
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, doc_q.size());
      while (doc_q.size() > cut) void'(doc_q.pop_back());
    end
    send_doc(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Capture with extreme bytes, a broken closing tag, then the real one
  task automatic test_capture_basic();
    add_text("<a>");
    doc_q.push_back(8'h00);
    doc_q.push_back(8'hFF);
    add_text("</b</a>");
    send_doc(1'b1);
  endtask

  // Empty name, end of data while a closing match is held
  task automatic test_end_of_data();
    add_text("< >q<");
    send_doc(1'b1);
  endtask

  // Head section is skipped, document ends inside it
  task automatic test_head_skip();
    add_text("<head>x");
    send_doc(1'b1);
  endtask

  // Doctype tag dropped, document ends inside an open tag
  task automatic test_doctype_drop();
    add_text("<!DOCTYPE><");
    send_doc(1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int min_bytes, input bit pause);
    int start;
    snd_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < min_bytes) begin
      rand_doc();
      if (pause) begin
        wait_drained();
        pause = 1'b0;
      end
    end
  endtask

  initial begin
    scanner_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_capture_basic();
    test_end_of_data();
    test_head_skip();
    test_doctype_drop();
    test_random_traffic(0, 0, 15, 1'b0);
    test_random_traffic(50, 0, 15, 1'b1);
    test_random_traffic(0, 50, 15, 1'b0);
    test_random_traffic(31, 31, 15, 1'b0);

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && extract_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mtce_pkg.sv
rtl/mtce_ctrl.sv
rtl/mtce_dp.sv
rtl/markup_tag_content_extractor_top.sv
dv/markup_tag_content_extractor_top_test.sv
